@@ rtl/core/adfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adfe_pkg
// shared constants, step codes and the item-to-output status struct for the
// ascii delimited frame encoder
// ----------------------------------------------------------------------------
package adfe_pkg;

   localparam int IdWidth      = 7;
   localparam int CrcWidth     = 16;
   localparam int ByteWidth    = 8;
   localparam int VerWidth     = 4;
   localparam int StepWidth    = 4;
   localparam int DigitWidth   = 4;

   // emission steps of one item, header first, trailer last
   localparam logic [StepWidth-1:0] STEP_STAR     = 4'd0;
   localparam logic [StepWidth-1:0] STEP_COLON    = 4'd1;
   localparam logic [StepWidth-1:0] STEP_ID_TENS  = 4'd2;
   localparam logic [StepWidth-1:0] STEP_ID_UNITS = 4'd3;
   localparam logic [StepWidth-1:0] STEP_HASH_ID  = 4'd4;
   localparam logic [StepWidth-1:0] STEP_VERSION  = 4'd5;
   localparam logic [StepWidth-1:0] STEP_HASH_VER = 4'd6;
   localparam logic [StepWidth-1:0] STEP_CRC_LSB  = 4'd7;
   localparam logic [StepWidth-1:0] STEP_CRC_MSB  = 4'd8;
   localparam logic [StepWidth-1:0] STEP_HASH_HDR = 4'd9;
   localparam logic [StepWidth-1:0] STEP_PAYLOAD  = 4'd10;
   localparam logic [StepWidth-1:0] STEP_TRL_COL  = 4'd11;
   localparam logic [StepWidth-1:0] STEP_TRL_HASH = 4'd12;

   localparam logic [ByteWidth-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [ByteWidth-1:0] CHAR_COLON = 8'h3A;
   localparam logic [ByteWidth-1:0] CHAR_HASH  = 8'h23;
   localparam logic [3:0]           CHAR_DIGIT_HI = 4'h3;

   localparam logic [VerWidth-1:0]  VERSION_RESET = 4'd2;
   localparam logic [ByteWidth-1:0] LENGTH_MAX    = 8'hFF;

   // item currently being emitted, from the item stage to the output stage
   typedef struct packed {
      logic                  valid;
      logic [StepWidth-1:0]  step;
      logic                  last_step;
      logic [DigitWidth-1:0] id_tens;
      logic [DigitWidth-1:0] id_units;
      logic [CrcWidth-1:0]   crc;
      logic [ByteWidth-1:0]  data;
   } adfe_cur_type;

endpackage

@@ rtl/core/adfe_item_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adfe_item_stage
// input register and step sequencer: plans the bytes of one item at accept
// and walks through them one per output transfer
// ----------------------------------------------------------------------------
module adfe_item_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [adfe_pkg::IdWidth-1:0]    frame_id,
   input  logic [adfe_pkg::CrcWidth-1:0]   crc_value,
   input  logic [adfe_pkg::ByteWidth-1:0]  payload_byte,
   input  logic                            byte_present,
   input  logic                            first_item,
   input  logic                            last_item,
   input  logic                            advance,
   output adfe_pkg::adfe_cur_type          cur
);
   import adfe_pkg::*;

   logic                  item_valid_ff, item_valid_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic                  pay_ff, trl_ff;
   logic [DigitWidth-1:0] tens_ff, units_ff;
   logic [CrcWidth-1:0]   crc_ff;
   logic [ByteWidth-1:0]  data_ff;
   logic                  in_frame_ff, in_frame_in;

   logic                  accept, active, plan_nonempty, last_step;
   logic [StepWidth-1:0]  start_step, next_step;
   logic [IdWidth-1:0]    id_mod, units_wide;
   logic [14:0]           tens_prod;
   logic [DigitWidth-1:0] id_tens;

   // id mod 100, then tens by reciprocal multiply (exact below 160 in the 15-bit product)
   assign id_mod     = (frame_id >= IdWidth'(100)) ? frame_id - IdWidth'(100) : frame_id;
   assign tens_prod  = 15'(id_mod) * 15'd205;
   assign id_tens    = tens_prod[14:11];
   assign units_wide = id_mod - {id_tens, 3'b000} - {2'b00, id_tens, 1'b0};

   assign active        = first_item | in_frame_ff;
   assign plan_nonempty = active & (first_item | byte_present | last_item);
   assign start_step    = first_item   ? STEP_STAR :
                          byte_present ? STEP_PAYLOAD : STEP_TRL_COL;

   always_comb begin
      next_step = step_ff + StepWidth'(1);
      last_step = 1'b0;
      case (step_ff)
         STEP_HASH_HDR: begin
            next_step = pay_ff ? STEP_PAYLOAD : STEP_TRL_COL;
            last_step = ~pay_ff & ~trl_ff;
         end
         STEP_PAYLOAD: begin
            next_step = STEP_TRL_COL;
            last_step = ~trl_ff;
         end
         STEP_TRL_HASH: begin
            last_step = 1'b1;
         end
         default: begin
            next_step = step_ff + StepWidth'(1);
         end
      endcase
   end

   assign req_tready = ~item_valid_ff | (advance & last_step);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      step_in       = step_ff;
      in_frame_in   = in_frame_ff;
      if (advance) begin
         if (last_step) begin
            item_valid_in = 1'b0;
         end else begin
            step_in = next_step;
         end
      end
      if (accept) begin
         item_valid_in = plan_nonempty;
         step_in       = start_step;
         in_frame_in   = active & ~last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         in_frame_ff   <= 1'b0;
         step_ff       <= STEP_STAR;
      end else begin
         item_valid_ff <= item_valid_in;
         in_frame_ff   <= in_frame_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pay_ff   <= byte_present;
         trl_ff   <= last_item;
         tens_ff  <= id_tens;
         units_ff <= units_wide[DigitWidth-1:0];
         crc_ff   <= crc_value;
         data_ff  <= payload_byte;
      end
   end

   assign cur.valid     = item_valid_ff;
   assign cur.step      = step_ff;
   assign cur.last_step = last_step;
   assign cur.id_tens   = tens_ff;
   assign cur.id_units  = units_ff;
   assign cur.crc       = crc_ff;
   assign cur.data      = data_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff |-> step_ff <= STEP_TRL_HASH)
      else $error("step code beyond trailer");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept && item_valid_ff |-> advance && last_step)
      else $error("item overwritten before its last byte left");

endmodule

@@ rtl/core/adfe_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adfe_out_stage
// byte select for the current step, frame length count and output register
// ----------------------------------------------------------------------------
module adfe_out_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  adfe_pkg::adfe_cur_type          cur,
   input  logic [adfe_pkg::VerWidth-1:0]   version,
   output logic                            advance,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [adfe_pkg::ByteWidth-1:0]  out_byte,
   output logic                            frame_end,
   output logic [adfe_pkg::ByteWidth-1:0]  frame_length
);
   import adfe_pkg::*;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ByteWidth-1:0] byte_ff, byte_in;
   logic                 end_ff, end_in;
   logic [ByteWidth-1:0] len_ff;
   logic [ByteWidth-1:0] count_ff, count_in;
   logic [VerWidth-1:0]  ver_digit;

   assign ver_digit = (version >= VerWidth'(10)) ? version - VerWidth'(10) : version;

   assign advance = cur.valid & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      case (cur.step)
         STEP_STAR:     byte_in = CHAR_STAR;
         STEP_COLON:    byte_in = CHAR_COLON;
         STEP_ID_TENS:  byte_in = {CHAR_DIGIT_HI, cur.id_tens};
         STEP_ID_UNITS: byte_in = {CHAR_DIGIT_HI, cur.id_units};
         STEP_HASH_ID:  byte_in = CHAR_HASH;
         STEP_VERSION:  byte_in = {CHAR_DIGIT_HI, ver_digit};
         STEP_HASH_VER: byte_in = CHAR_HASH;
         STEP_CRC_LSB:  byte_in = cur.crc[7:0];
         STEP_CRC_MSB:  byte_in = cur.crc[15:8];
         STEP_HASH_HDR: byte_in = CHAR_HASH;
         STEP_PAYLOAD:  byte_in = cur.data;
         STEP_TRL_COL:  byte_in = CHAR_COLON;
         STEP_TRL_HASH: byte_in = CHAR_HASH;
         default:       byte_in = CHAR_HASH;
      endcase
   end

   assign end_in = (cur.step == STEP_TRL_HASH);

   // header start restarts the length, otherwise saturating increment
   always_comb begin
      if (cur.step == STEP_STAR) begin
         count_in = ByteWidth'(1);
      end else if (count_ff == LENGTH_MAX) begin
         count_in = LENGTH_MAX;
      end else begin
         count_in = count_ff + ByteWidth'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
         len_ff  <= count_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign out_byte     = byte_ff;
   assign frame_end    = end_ff;
   assign frame_length = len_ff;

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> len_ff != '0)
      else $error("result with zero frame length");

   a_end_is_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && end_ff |-> byte_ff == CHAR_HASH)
      else $error("frame end on a byte other than the closing hash");

endmodule

@@ rtl/core/ascii_delimited_frame_encoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_delimited_frame_encoder_core
// stream encoder that wraps payload bytes in '*:' id '#' ver '#' crc '#' ... ':#'
// ----------------------------------------------------------------------------
// The block gives one output byte per clock while an item is held and
// rsp_tready is high, and holds each input item until its last byte leaves.
// An item with first set yields the ten header bytes, a present payload byte
// yields itself, and last adds the two trailer bytes, so the step sequencer in
// the item stage walks at most 13 bytes per item, or none. Plain payload items
// are taken back to back. The first output byte reaches rsp_ through the item
// register, then the output register. Items outside an open frame (first
// clear, no frame open) are taken and dropped. frame_length counts the bytes
// of the current frame including the present one, saturating at 255, and is
// the total when rsp_tlast is high. protocol_version is written through csr_
// and should only change while the block is idle.
// ----------------------------------------------------------------------------
module ascii_delimited_frame_encoder_core (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,   // protocol_version
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // frame_id[6:0], crc_value[22:7], payload_byte[30:23], zero[31]
   input  logic [1:0]  req_tuser,     // byte_present[0], first_item[1]
   input  logic        req_tlast,     // last_item
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // out_byte[7:0], frame_length[15:8]
   output logic        rsp_tlast      // frame_end
);
   import adfe_pkg::*;

   // version register, reset to the default digit
   logic [VerWidth-1:0]  version_ff;

   adfe_cur_type         cur;
   logic                 advance;
   logic [ByteWidth-1:0] out_byte;
   logic [ByteWidth-1:0] frame_length;
   logic                 frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
      end else if (csr_wr_en) begin
         version_ff <= csr_wr_data;
      end
   end

   // input register and step sequencer, also tracks whether a frame is open
   adfe_item_stage u_item (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .frame_id     (req_tdata[6:0]),
      .crc_value    (req_tdata[22:7]),
      .payload_byte (req_tdata[30:23]),
      .byte_present (req_tuser[0]),
      .first_item   (req_tuser[1]),
      .last_item    (req_tlast),
      .advance      (advance),
      .cur          (cur)
   );

   // byte select, frame length and the output register
   adfe_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .cur          (cur),
      .version      (version_ff),
      .advance      (advance),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .out_byte     (out_byte),
      .frame_end    (frame_end),
      .frame_length (frame_length)
   );

   // pack the result transfer
   assign rsp_tdata = {frame_length, out_byte};
   assign rsp_tlast = frame_end;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ascii delimited frame encoder: a queue-fed
// driver offers payload items, a local frame builder predicts every encoded
// byte, and a monitor compares each output transfer with the oldest
// prediction under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module tb;
   import adfe_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [IdWidth-1:0]   id;
      logic [CrcWidth-1:0]  crc;
      logic [ByteWidth-1:0] data;
      bit                   present;
      bit                   first;
      bit                   last;
   } frame_item_type;

   typedef struct {
      logic [ByteWidth-1:0] data;
      bit                   frame_end;
      logic [ByteWidth-1:0] length;
   } enc_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // frame_id[6:0], crc_value[22:7], payload_byte[30:23], zero[31]
   logic [1:0]  req_tuser = '0;   // byte_present[0], first_item[1]
   logic        req_tlast = 1'b0; // last_item
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // out_byte[7:0], frame_length[15:8]
   logic        rsp_tlast;        // frame_end

   // stimulus and prediction state
   frame_item_type pending_items[$];
   enc_byte_type   enc_bytes_q[$];
   frame_item_type offered;
   bit          item_taken = 1'b0;
   int          items_queued = 0;
   int          items_taken = 0;
   int          tx_idle_pct = 33;
   int          rx_idle_pct = 33;
   int          rx_hold_left = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   // shadow of the encoder state
   logic [VerWidth-1:0]  version_reg = VERSION_RESET;
   bit                   in_frame = 1'b0;
   logic [ByteWidth-1:0] frame_bytes = '0;

   ascii_delimited_frame_encoder_core DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
   endtask

   // one predicted output byte, frame length counts it and saturates
   task automatic push_byte(input logic [ByteWidth-1:0] b, input bit fin);
      enc_byte_type e;
      if (frame_bytes != LENGTH_MAX) frame_bytes++;
      e.data = b;
      e.frame_end = fin;
      e.length = frame_bytes;
      enc_bytes_q.push_back(e);
   endtask

   // expected bytes of one accepted item
   task automatic encode_item(input frame_item_type it);
      logic [IdWidth-1:0] idv;
      if (it.first) begin
         // id above 99 only keeps its two low decimal digits
         idv = it.id % 7'd100;
         in_frame = 1'b1;
         frame_bytes = '0;
         push_byte(CHAR_STAR, 1'b0);
         push_byte(CHAR_COLON, 1'b0);
         push_byte({CHAR_DIGIT_HI, 4'(idv / 7'd10)}, 1'b0);
         push_byte({CHAR_DIGIT_HI, 4'(idv % 7'd10)}, 1'b0);
         push_byte(CHAR_HASH, 1'b0);
         push_byte({CHAR_DIGIT_HI, 4'(version_reg % 4'd10)}, 1'b0);
         push_byte(CHAR_HASH, 1'b0);
         push_byte(it.crc[7:0], 1'b0);
         push_byte(it.crc[15:8], 1'b0);
         push_byte(CHAR_HASH, 1'b0);
      end
      // items with no open frame are dropped
      if (in_frame) begin
         if (it.present) push_byte(it.data, 1'b0);
         if (it.last) begin
            push_byte(CHAR_COLON, 1'b0);
            push_byte(CHAR_HASH, 1'b1);
            in_frame = 1'b0;
         end
      end
   endtask

   task automatic add_item(input logic [IdWidth-1:0] id, input logic [CrcWidth-1:0] crc,
                           input logic [ByteWidth-1:0] data, input bit present,
                           input bit first, input bit last);
      frame_item_type it;
      it.id = id;
      it.crc = crc;
      it.data = data;
      it.present = present;
      it.first = first;
      it.last = last;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // mostly well-formed frames, some cut short, some stray items between them
   task automatic add_random_items(input int count);
      int added;
      int kind;
      int n;
      logic [IdWidth-1:0] id;
      logic [CrcWidth-1:0] crc;
      added = 0;
      while (added < count) begin
         kind = $urandom_range(99);
         n = $urandom_range(1, 8);
         id = ($urandom_range(9) == 0) ? IdWidth'($urandom_range(127))
                                       : IdWidth'($urandom_range(99));
         crc = CrcWidth'($urandom);
         if (kind < 7) begin
            for (int i = 0; i < n % 4 + 1; i++)
               add_item(IdWidth'($urandom), CrcWidth'($urandom), ByteWidth'($urandom),
                        $urandom_range(1), 1'b0, $urandom_range(1));
            added += n % 4 + 1;
         end else begin
            for (int i = 0; i < n; i++)
               add_item(id, crc, ByteWidth'($urandom), $urandom_range(4) != 0,
                        i == 0, (kind >= 15) && (i == n - 1));
            added += n;
         end
      end
   endtask

   // block until every queued item is taken and every predicted byte came out
   task automatic wait_drained();
      while (items_taken != items_queued || enc_bytes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_version(input logic [VerWidth-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      version_reg = v;
   endtask

   // source side: a new item goes out only after the previous transfer
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || item_taken)) begin
         item_taken = 1'b0;
         if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            offered = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {1'b0, offered.data, offered.crc, offered.id};
            req_tuser <= {offered.first, offered.present};
            req_tlast <= offered.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // input transfer: predict its bytes right away
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         encode_item(offered);
         items_taken++;
         item_taken = 1'b1;
      end
   end

   // sink side: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (rx_hold_left != 0) begin
         rsp_tready <= 1'b0;
         rx_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // output transfer against the oldest prediction
   always @(posedge clock) begin : output_check
      enc_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (enc_bytes_q.size() == 0) begin
            report_mismatch("unexpected output byte", rsp_tdata[7:0], 0);
         end else begin
            want = enc_bytes_q.pop_front();
            if (rsp_tdata[7:0] !== want.data)
               report_mismatch("out_byte", rsp_tdata[7:0], want.data);
            if (rsp_tlast !== want.frame_end)
               report_mismatch("frame_end", rsp_tlast, want.frame_end);
            if (rsp_tdata[15:8] !== want.length)
               report_mismatch("frame_length", rsp_tdata[15:8], want.length);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset version
      add_item(7'd5, 16'h1111, 8'h55, 1'b1, 1'b0, 1'b1);     // no frame open, dropped
      add_item(7'd0, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b0);
      add_item(7'd0, 16'h0000, 8'hFF, 1'b1, 1'b0, 1'b0);
      add_item(7'd0, 16'h0000, 8'h3C, 1'b0, 1'b0, 1'b0);     // empty item
      add_item(7'd0, 16'h0000, 8'hC3, 1'b0, 1'b0, 1'b1);     // trailer only
      add_item(7'd99, 16'hFFFF, 8'hA5, 1'b1, 1'b1, 1'b1);    // whole frame in one item
      add_item(7'd127, 16'h1234, 8'h5A, 1'b0, 1'b1, 1'b1);   // id wraps, no payload
      add_item(7'd42, 16'h8001, 8'h01, 1'b1, 1'b1, 1'b0);
      add_item(7'd0, 16'h0000, 8'h80, 1'b1, 1'b0, 1'b0);
      add_item(7'd100, 16'h00FF, 8'h7F, 1'b0, 1'b1, 1'b0);   // restart an open frame
      add_item(7'd64, 16'hFF00, 8'hFE, 1'b1, 1'b0, 1'b1);
      add_item(7'd1, 16'h0002, 8'h03, 1'b1, 1'b0, 1'b0);     // stray after close
      add_item(7'd9, 16'hAAAA, 8'h55, 1'b1, 1'b1, 1'b0);
      add_item(7'd0, 16'h5555, 8'hAA, 1'b1, 1'b0, 1'b0);
      add_item(7'd0, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1);
      wait_drained();

      // highest legal digit, normal random gaps
      write_version(4'd9);
      add_random_items(45);
      wait_drained();

      // version above nine, a long stretch with no gaps on either side
      write_version(4'd15);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      add_random_items(45);
      wait_drained();

      // sink holds off while the source keeps offering, so the input backs up
      write_version(4'd0);
      rx_idle_pct = 33;
      rx_hold_left = 300;
      add_random_items(45);
      wait_drained();

      // version above nine on a longer frame
      write_version(4'd12);
      tx_idle_pct = 33;
      add_item(7'd77, CrcWidth'($urandom), ByteWidth'($urandom), 1'b1, 1'b1, 1'b0);
      for (int i = 0; i < 16; i++)
         add_item(7'd0, 16'h0000, ByteWidth'($urandom), $urandom_range(9) != 0, 1'b0, 1'b0);
      add_item(7'd0, 16'h0000, ByteWidth'($urandom), 1'b1, 1'b0, 1'b1);
      wait_drained();

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
